### sv/sha1_pkg.sv
// sha1_pkg: shared types, constants and round functions of the SHA-1 engine.
// Used by sha1_ctrl, sha1_dpath and sha1_hash_engine_unit; depends on nothing.
package sha1_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned NUM_ROUNDS     = 80;
    localparam int unsigned ROUND_W        = 7;
    localparam int unsigned DIGEST_WORDS   = 5;
    localparam int unsigned BLOCK_WORDS    = 16;
    localparam int unsigned PAD_LENGTH_POS = 448;

    localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(NUM_ROUNDS - 1);
    localparam logic [ROUND_W-1:0] PHASE1_START = ROUND_W'(20);
    localparam logic [ROUND_W-1:0] PHASE2_START = ROUND_W'(40);
    localparam logic [ROUND_W-1:0] PHASE3_START = ROUND_W'(60);

    // First byte position of the length field within a block.
    localparam logic [5:0] LENGTH_BYTE_POS = 6'(PAD_LENGTH_POS / 8);
    localparam logic [5:0] LAST_BYTE_POS   = 6'd63;
    localparam logic [7:0] PAD_BYTE        = 8'h80;
    localparam logic [2:0] LAST_WORD_INDEX = 3'(DIGEST_WORDS - 1);

    localparam word_t H_INIT0 = 32'h67452301;
    localparam word_t H_INIT1 = 32'hEFCDAB89;
    localparam word_t H_INIT2 = 32'h98BADCFE;
    localparam word_t H_INIT3 = 32'h10325476;
    localparam word_t H_INIT4 = 32'hC3D2E1F0;

    localparam word_t K_PHASE0 = 32'h5A827999;
    localparam word_t K_PHASE1 = 32'h6ED9EBA1;
    localparam word_t K_PHASE2 = 32'h8F1BBCDC;
    localparam word_t K_PHASE3 = 32'hCA62C1D6;

    // Commands from the controller to the datapath. Several may be set at once.
    typedef struct packed {
        logic               absorb;    // write data_byte into the block store
        logic               pad;       // write 0x80, zero fill, and length if it fits
        logic               zlen;      // zero block with length only
        logic               load;      // start compression: copy block and chain
        logic               round;     // run one round
        logic               add;       // fold working state into the chain value
        logic               finish;    // fold into the digest buffer and restart
        logic [ROUND_W-1:0] round_idx;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_byte_pos;  // next byte completes a block
        logic two_block;      // padding spills into an extra block
        logic out_busy;       // digest buffer still holds undelivered words
    } dp_stat_t;

    function automatic word_t round_f(input logic [ROUND_W-1:0] t,
                                      input word_t b, input word_t c, input word_t d);
        word_t f;
        if (t < PHASE1_START) begin
            f = (b & c) | (~b & d);
        end else if (t < PHASE2_START) begin
            f = b ^ c ^ d;
        end else if (t < PHASE3_START) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic word_t round_k(input logic [ROUND_W-1:0] t);
        word_t k;
        if (t < PHASE1_START) begin
            k = K_PHASE0;
        end else if (t < PHASE2_START) begin
            k = K_PHASE1;
        end else if (t < PHASE3_START) begin
            k = K_PHASE2;
        end else begin
            k = K_PHASE3;
        end
        return k;
    endfunction

endpackage

### sv/sha1_in_if.sv
// sha1_in_if: input channel of the SHA-1 engine, one message byte a beat.
// Depends on nothing.
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface

### sv/sha1_out_if.sv
// sha1_out_if: output channel of the SHA-1 engine, one digest word a beat.
// Depends on nothing.
interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

### sv/sha1_ctrl.sv
// sha1_ctrl: sequencing state machine of the SHA-1 engine.
// Depends on sha1_pkg and sha1_in_if; drives the datapath through dp_cmd_t.
module sha1_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    sha1_in_if.sink            in_ch,
    input  sha1_pkg::dp_stat_t stat,
    output sha1_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_ZLEN  = 3'd4;

    // What follows the compression that is running.
    localparam logic [1:0] AFTER_IDLE = 2'd0;
    localparam logic [1:0] AFTER_PAD  = 2'd1;
    localparam logic [1:0] AFTER_ZLEN = 2'd2;
    localparam logic [1:0] AFTER_OUT  = 2'd3;

    localparam logic [sha1_pkg::ROUND_W-1:0] ROUND_ONE =
        {{(sha1_pkg::ROUND_W-1){1'b0}}, 1'b1};

    logic [2:0]                   state_reg, state_next;
    logic [1:0]                   after_reg, after_next;
    logic [sha1_pkg::ROUND_W-1:0] round_reg, round_next;
    logic                         accept;

    // Bytes of the next block may come in while rounds run, as long as the
    // byte would not complete a block and no end of message is pending.
    assign in_ch.ready = (state_reg == ST_IDLE) ||
                         (state_reg == ST_ROUND && after_reg == AFTER_IDLE &&
                          !stat.last_byte_pos);
    assign accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        cmd           = '0;
        cmd.round_idx = round_reg;
        state_next    = state_reg;
        after_next    = after_reg;
        round_next    = round_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    cmd.absorb = in_ch.byte_valid;
                    if (in_ch.byte_valid && stat.last_byte_pos) begin
                        cmd.load   = 1'b1;
                        round_next = '0;
                        state_next = ST_ROUND;
                        after_next = in_ch.end_of_message ? AFTER_PAD : AFTER_IDLE;
                    end else if (in_ch.end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (accept) begin
                    cmd.absorb = in_ch.byte_valid;
                    if (in_ch.end_of_message) begin
                        after_next = AFTER_PAD;
                    end
                end
                if (round_reg == sha1_pkg::LAST_ROUND) begin
                    state_next = ST_ADD;
                end else begin
                    round_next = round_reg + ROUND_ONE;
                end
            end
            ST_ADD:
            begin
                case (after_reg)
                    AFTER_PAD:
                    begin
                        cmd.add    = 1'b1;
                        state_next = ST_PAD;
                    end
                    AFTER_ZLEN:
                    begin
                        cmd.add    = 1'b1;
                        state_next = ST_ZLEN;
                    end
                    AFTER_OUT:
                    begin
                        // Wait until the previous digest has fully left.
                        if (!stat.out_busy) begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                            after_next = AFTER_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.add    = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_PAD:
            begin
                cmd.pad    = 1'b1;
                cmd.load   = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
                after_next = stat.two_block ? AFTER_ZLEN : AFTER_OUT;
            end
            ST_ZLEN:
            begin
                cmd.zlen   = 1'b1;
                cmd.load   = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
                after_next = AFTER_OUT;
            end
            default:
            begin
                state_next = ST_IDLE;
                after_next = AFTER_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            after_reg <= AFTER_IDLE;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
            round_reg <= round_next;
        end
    end

endmodule

### sv/sha1_dpath.sv
// sha1_dpath: block store, message schedule, round logic, chain value,
// bit count and digest buffer. Depends on sha1_pkg and sha1_out_if.
module sha1_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  sha1_pkg::dp_cmd_t  cmd,
    input  logic [7:0]         data_byte,
    output sha1_pkg::dp_stat_t stat,
    sha1_out_if.source         out_ch
);

    localparam int unsigned BW = sha1_pkg::BLOCK_WORDS;
    localparam int unsigned DW = sha1_pkg::DIGEST_WORDS;

    sha1_pkg::word_t blk_reg [BW];
    sha1_pkg::word_t blk_next[BW];
    sha1_pkg::word_t sch_reg [BW];
    sha1_pkg::word_t sch_next[BW];
    sha1_pkg::word_t h_reg   [DW];
    sha1_pkg::word_t h_next  [DW];
    sha1_pkg::word_t st_reg  [DW];
    sha1_pkg::word_t st_next [DW];
    sha1_pkg::word_t dig_reg [DW];
    sha1_pkg::word_t dig_next[DW];
    sha1_pkg::word_t h_init  [DW];

    // Message length in bytes; the bit count is this shifted left by three.
    logic [60:0] byte_cnt_reg, byte_cnt_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_busy_reg, out_busy_next;
    logic [5:0]  pos;
    logic [63:0] bit_len;
    logic        out_take;
    sha1_pkg::word_t temp;

    assign h_init[0] = sha1_pkg::H_INIT0;
    assign h_init[1] = sha1_pkg::H_INIT1;
    assign h_init[2] = sha1_pkg::H_INIT2;
    assign h_init[3] = sha1_pkg::H_INIT3;
    assign h_init[4] = sha1_pkg::H_INIT4;

    assign pos     = byte_cnt_reg[5:0];
    assign bit_len = {byte_cnt_reg, 3'b000};

    assign stat.last_byte_pos = (pos == sha1_pkg::LAST_BYTE_POS);
    assign stat.two_block     = (pos >= sha1_pkg::LENGTH_BYTE_POS);
    assign stat.out_busy      = out_busy_reg;

    assign out_ch.valid       = out_busy_reg;
    assign out_ch.digest_word = dig_reg[0];
    assign out_ch.word_index  = out_idx_reg;
    assign out_ch.last_word   = (out_idx_reg == sha1_pkg::LAST_WORD_INDEX);
    assign out_take           = out_ch.valid && out_ch.ready;

    // Block store: byte writes, padding and the length-only block.
    always_comb
    begin
        for (int i = 0; i < BW; i++) begin
            blk_next[i] = blk_reg[i];
        end
        if (cmd.absorb) begin
            for (int i = 0; i < BW; i++) begin
                if (4'(i) == pos[5:2]) begin
                    for (int j = 0; j < 4; j++) begin
                        if (2'(j) == pos[1:0]) begin
                            blk_next[i][8*(3-j) +: 8] = data_byte;
                        end
                    end
                end
            end
        end
        if (cmd.pad) begin
            // Keep the bytes before the pad, place 0x80, clear the rest.
            for (int i = 0; i < BW; i++) begin
                if (4'(i) == pos[5:2]) begin
                    for (int j = 0; j < 4; j++) begin
                        if (2'(j) == pos[1:0]) begin
                            blk_next[i][8*(3-j) +: 8] = sha1_pkg::PAD_BYTE;
                        end else if (2'(j) > pos[1:0]) begin
                            blk_next[i][8*(3-j) +: 8] = '0;
                        end
                    end
                end else if (4'(i) > pos[5:2]) begin
                    blk_next[i] = '0;
                end
            end
            if (!stat.two_block) begin
                blk_next[BW-2] = bit_len[63:32];
                blk_next[BW-1] = bit_len[31:0];
            end
        end
        if (cmd.zlen) begin
            for (int i = 0; i < BW - 2; i++) begin
                blk_next[i] = '0;
            end
            blk_next[BW-2] = bit_len[63:32];
            blk_next[BW-1] = bit_len[31:0];
        end
    end

    // Message schedule as a 16-word shift line; the head is W[t].
    always_comb
    begin
        for (int i = 0; i < BW; i++) begin
            sch_next[i] = sch_reg[i];
        end
        if (cmd.load) begin
            for (int i = 0; i < BW; i++) begin
                sch_next[i] = blk_next[i];
            end
        end else if (cmd.round) begin
            for (int i = 0; i < BW - 1; i++) begin
                sch_next[i] = sch_reg[i+1];
            end
            sch_next[BW-1] = {sch_reg[13][30:0] ^ sch_reg[8][30:0] ^
                              sch_reg[2][30:0] ^ sch_reg[0][30:0],
                              sch_reg[13][31] ^ sch_reg[8][31] ^
                              sch_reg[2][31] ^ sch_reg[0][31]};
        end
    end

    // Round, chain update, digest buffer and output drain.
    always_comb
    begin
        temp = {st_reg[0][26:0], st_reg[0][31:27]} +
               sha1_pkg::round_f(cmd.round_idx, st_reg[1], st_reg[2], st_reg[3]) +
               st_reg[4] + sha1_pkg::round_k(cmd.round_idx) + sch_reg[0];

        for (int i = 0; i < DW; i++) begin
            st_next[i]  = st_reg[i];
            h_next[i]   = h_reg[i];
            dig_next[i] = dig_reg[i];
        end
        byte_cnt_next = byte_cnt_reg;
        out_idx_next  = out_idx_reg;
        out_busy_next = out_busy_reg;

        if (cmd.load) begin
            for (int i = 0; i < DW; i++) begin
                st_next[i] = h_reg[i];
            end
        end else if (cmd.round) begin
            st_next[0] = temp;
            st_next[1] = st_reg[0];
            st_next[2] = {st_reg[1][1:0], st_reg[1][31:2]};
            st_next[3] = st_reg[2];
            st_next[4] = st_reg[3];
        end

        if (cmd.absorb) begin
            byte_cnt_next = byte_cnt_reg + 61'd1;
        end

        if (cmd.add) begin
            for (int i = 0; i < DW; i++) begin
                h_next[i] = h_reg[i] + st_reg[i];
            end
        end

        if (out_take) begin
            for (int i = 0; i < DW - 1; i++) begin
                dig_next[i] = dig_reg[i+1];
            end
            if (out_ch.last_word) begin
                out_idx_next  = '0;
                out_busy_next = 1'b0;
            end else begin
                out_idx_next = out_idx_reg + 3'd1;
            end
        end

        if (cmd.finish) begin
            for (int i = 0; i < DW; i++) begin
                dig_next[i] = h_reg[i] + st_reg[i];
                h_next[i]   = h_init[i];
            end
            byte_cnt_next = '0;
            out_idx_next  = '0;
            out_busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BW; i++) begin
            blk_reg[i] <= blk_next[i];
            sch_reg[i] <= sch_next[i];
        end
        for (int i = 0; i < DW; i++) begin
            st_reg[i]  <= st_next[i];
            dig_reg[i] <= dig_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < DW; i++) begin
                h_reg[i] <= h_init[i];
            end
            byte_cnt_reg <= '0;
            out_idx_reg  <= '0;
            out_busy_reg <= 1'b0;
        end else begin
            for (int i = 0; i < DW; i++) begin
                h_reg[i] <= h_next[i];
            end
            byte_cnt_reg <= byte_cnt_next;
            out_idx_reg  <= out_idx_next;
            out_busy_reg <= out_busy_next;
        end
    end

endmodule

### sv/sha1_hash_engine_unit.sv
// sha1_hash_engine_unit: top level of the SHA-1 streaming hash engine.
// Depends on sha1_pkg, sha1_in_if, sha1_out_if, sha1_ctrl and sha1_dpath.
//
//  Channel  Role    Beat payload
//  -------  ------  ---------------------------------------------------
//  in_ch    sink    data_byte[7:0], byte_valid, end_of_message
//  out_ch   source  digest_word[31:0], word_index[2:0], last_word
//
// The byte that completes a 64-byte block also loads the schedule, then
// 80 rounds follow, one round per cycle on a single round unit, and a
// fold step adds the result into the chain value. Up to 63 bytes of the
// following block are taken during those 80 rounds.
// After the end-of-message beat, each padding block (one or two) takes a
// step that writes the padding and loads the schedule, 80 rounds and the
// fold. Then five digest beats leave, one after another, while the next
// message is already coming in.
// Reset clears the controller, the bit count, the output busy flag and
// word index, and loads the initial chain value; no clearing pass is needed.
// Stalls: out_ch back-pressure holds the digest buffer; a second digest
// waits in the fold cycle until the first has left completely.
module sha1_hash_engine_unit (
    input  logic       clk,
    input  logic       rst_n,
    sha1_in_if.sink    in_ch,
    sha1_out_if.source out_ch
);

    // Command and status between the sequencer and the datapath.
    sha1_pkg::dp_cmd_t  cmd;
    sha1_pkg::dp_stat_t stat;

    // The controller owns the input handshake and all sequencing: byte
    // intake, block compressions, the padding block(s) and the hand-off
    // of the finished digest.
    sha1_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .stat  (stat),
        .cmd   (cmd)
    );

    // The datapath holds all hash storage and arithmetic, and drains the
    // digest buffer onto the output channel on its own.
    sha1_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_ch.data_byte),
        .stat      (stat),
        .out_ch    (out_ch)
    );

    // A new digest is never written over words that are still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_ch.valid)
        else $error("digest buffer overwritten before it drained");

    // A byte taken during the rounds never completes a block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && cmd.round) |-> !stat.last_byte_pos)
        else $error("block-completing byte taken while compressing");

    // Digest words leave in order with no gaps in the index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last_word) |=>
            (out_ch.valid && out_ch.word_index == $past(out_ch.word_index) + 3'd1))
        else $error("digest word sequence broken");

    // After the last word is taken, the buffer is empty in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last_word) |=> !out_ch.valid)
        else $error("digest buffer not released after last word");

endmodule
